// ----- hdl/magic_udp_frame_throughput_meter_defines.svh -----
// Assertion macros for the throughput meter checker.
`ifndef MAGIC_UDP_FRAME_THROUGHPUT_METER_DEFINES_SVH
`define MAGIC_UDP_FRAME_THROUGHPUT_METER_DEFINES_SVH

// Check on every edge outside reset.
`define MUTM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("throughput meter check failed");

// Check on every edge, reset included.
`define MUTM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("throughput meter check failed");

`endif

// ----- hdl/mutm_pkg.sv -----
`timescale 1ns / 1ps
// Beat types, protocol constants and the greeting table of the throughput meter.
package mutm_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_beat_t;

    typedef struct packed {
        logic [1:0]  frame_class;
        logic [31:0] interval_ms;
        logic [50:0] accepted_kbits;
        logic [51:0] raw_kbits;
        logic [47:0] accepted_bytes;
        logic [47:0] dropped_bytes;
        logic [31:0] accepted_packets;
        logic [31:0] dropped_packets;
    } result_beat_t;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLASS_FOR_US  = 2'd1;
    localparam logic [1:0] CLASS_MAGIC   = 2'd2;

    localparam int MAC_LEN       = 6;
    localparam int IHL_POS       = 14;
    localparam int PROTO_POS     = 23;
    localparam int PAYLOAD_BASE  = 22;
    localparam int MIN_FRAME_LEN = 24;
    localparam int HDR_LEN_MAX   = 60;

    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [5:0] HDR_LEN_RESET = 6'd20;

    localparam int DIV_STEPS = 49;

    function automatic logic [7:0] greeting_byte(input logic [5:0] pos);
        logic [7:0] b;
        case (pos)
            6'd0:    b = 8'h48;
            6'd1:    b = 8'h65;
            6'd2:    b = 8'h6c;
            6'd3:    b = 8'h6c;
            6'd4:    b = 8'h6f;
            6'd5:    b = 8'h20;
            6'd6:    b = 8'h77;
            6'd7:    b = 8'h6f;
            6'd8:    b = 8'h72;
            6'd9:    b = 8'h6c;
            6'd10:   b = 8'h64;
            6'd11:   b = 8'h21;
            6'd12:   b = 8'h20;
            6'd13:   b = 8'h47;
            6'd14:   b = 8'h65;
            6'd15:   b = 8'h6e;
            6'd16:   b = 8'h6f;
            6'd17:   b = 8'h64;
            6'd18:   b = 8'h65;
            6'd19:   b = 8'h20;
            6'd20:   b = 8'h69;
            6'd21:   b = 8'h73;
            6'd22:   b = 8'h20;
            6'd23:   b = 8'h67;
            6'd24:   b = 8'h72;
            6'd25:   b = 8'h65;
            6'd26:   b = 8'h65;
            6'd27:   b = 8'h74;
            6'd28:   b = 8'h69;
            6'd29:   b = 8'h6e;
            6'd30:   b = 8'h67;
            6'd31:   b = 8'h2e;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/magic_udp_frame_throughput_meter.sv -----
`timescale 1ns / 1ps
// Top level of the UDP greeting-frame throughput meter.
// Frame bytes and millisecond ticks enter as beats, one beat per cycle while frame_stall is low.
// Every frame produces one result beat; ordinary frames report only the class, at their last byte.
// For a greeting frame, the two throughput quotients come after its last beat from
// a restoring divider that shifts the 49-bit byte totals through one bit per cycle (49 steps),
// then ST_SEND loads them into the result register; frame_stall stays high meanwhile. The result
// register holds one result beat, and while result_stall keeps it waiting no new beat enters.
module magic_udp_frame_throughput_meter #(
    parameter int MAX_FRAME_BYTES = 2048,
    parameter int MAGIC_BYTES     = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mac_wr_en,
    input  logic [47:0]            mac_wr_data,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  mutm_pkg::frame_beat_t  frame_beat,
    output logic                   result_valid,
    input  logic                   result_stall,
    output mutm_pkg::result_beat_t result_beat
);
    import mutm_pkg::*;

    localparam int POS_W     = $clog2(MAX_FRAME_BYTES + 1);
    localparam int END_W     = $clog2(PAYLOAD_BASE + HDR_LEN_MAX + MAGIC_BYTES + 1);
    localparam int CMP_W     = (POS_W > END_W) ? POS_W : END_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [47:0]          mac_reg, mac_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [5:0]           hl_reg, hl_next;
    logic [1:0]           class_reg, class_next;
    logic [31:0]          ms_reg, ms_next;
    logic [31:0]          mark_reg, mark_next;
    logic [47:0]          acc_bytes_reg, acc_bytes_next;
    logic [47:0]          drop_bytes_reg, drop_bytes_next;
    logic [31:0]          acc_pkts_reg, acc_pkts_next;
    logic [31:0]          drop_pkts_reg, drop_pkts_next;
    logic                 out_valid_reg, out_valid_next;

    result_beat_t         out_beat_reg, out_beat_next;
    result_beat_t         meas_reg, meas_next;
    logic [48:0]          acc_q_reg, acc_q_next;
    logic [48:0]          raw_q_reg, raw_q_next;
    logic [31:0]          acc_rem_reg, acc_rem_next;
    logic [31:0]          raw_rem_reg, raw_rem_next;
    logic [31:0]          divisor_reg, divisor_next;

    logic                 take;
    logic                 slot_free;
    logic [CMP_W-1:0]     idx;
    logic [CMP_W-1:0]     win_start;
    logic [CMP_W-1:0]     win_end;
    logic [CMP_W-1:0]     greet_off;
    logic [CMP_W-1:0]     min_need;
    logic [7:0]           mac_want;
    logic [5:0]           hl_byte;
    logic [1:0]           cls_byte;
    logic [1:0]           cls_final;
    logic [POS_W-1:0]     pos_inc;
    logic [48:0]          acc_bytes_sum;
    logic [48:0]          drop_bytes_sum;
    logic [32:0]          acc_pkts_sum;
    logic [32:0]          drop_pkts_sum;
    logic [47:0]          acc_bytes_sat;
    logic [47:0]          drop_bytes_sat;
    logic [31:0]          acc_pkts_sat;
    logic [31:0]          drop_pkts_sat;
    logic [31:0]          elapsed;
    logic [32:0]          acc_shift, raw_shift;
    logic [32:0]          acc_diff, raw_diff;
    logic                 acc_ge, raw_ge;

    assign slot_free   = !out_valid_reg || !result_stall;
    assign frame_stall = (state_reg != ST_RUN) || !slot_free;
    assign take        = frame_valid && !frame_stall;

    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

    always_comb
    begin
        case (pos_reg[2:0])
            3'd0:    mac_want = mac_reg[47:40];
            3'd1:    mac_want = mac_reg[39:32];
            3'd2:    mac_want = mac_reg[31:24];
            3'd3:    mac_want = mac_reg[23:16];
            3'd4:    mac_want = mac_reg[15:8];
            3'd5:    mac_want = mac_reg[7:0];
            default: mac_want = 8'h00;
        endcase
    end

    // Examine one frame byte against the running classification.
    always_comb
    begin
        idx       = CMP_W'(pos_reg);
        win_start = CMP_W'(PAYLOAD_BASE) + CMP_W'(hl_reg);
        win_end   = win_start + CMP_W'(MAGIC_BYTES);
        greet_off = idx - win_start;
        hl_byte   = hl_reg;
        cls_byte  = class_reg;
        pos_inc   = pos_reg;
        if (pos_reg < MAX_POS)
        begin
            pos_inc = pos_reg + POS_W'(1);
            if (idx < CMP_W'(MAC_LEN) && frame_beat.frame_byte != mac_want)
                cls_byte = CLASS_UNKNOWN;
            if (idx == CMP_W'(IHL_POS))
                hl_byte = {frame_beat.frame_byte[3:0], 2'b00};
            if (idx == CMP_W'(PROTO_POS) && frame_beat.frame_byte != PROTO_UDP)
                cls_byte = CLASS_UNKNOWN;
            if (idx >= win_start && idx < win_end && cls_byte == CLASS_MAGIC
                && frame_beat.frame_byte != greeting_byte(greet_off[5:0]))
                cls_byte = CLASS_FOR_US;
        end
        min_need  = CMP_W'(PAYLOAD_BASE) + CMP_W'(hl_byte) + CMP_W'(MAGIC_BYTES);
        cls_final = cls_byte;
        if (CMP_W'(pos_inc) < CMP_W'(MIN_FRAME_LEN))
            cls_final = CLASS_UNKNOWN;
        else if (cls_byte == CLASS_MAGIC && CMP_W'(pos_inc) < min_need)
            cls_final = CLASS_FOR_US;
    end

    always_comb
    begin
        acc_bytes_sum  = {1'b0, acc_bytes_reg} + 49'(pos_inc);
        drop_bytes_sum = {1'b0, drop_bytes_reg} + 49'(pos_inc);
        acc_pkts_sum   = {1'b0, acc_pkts_reg} + 33'd1;
        drop_pkts_sum  = {1'b0, drop_pkts_reg} + 33'd1;
        acc_bytes_sat  = acc_bytes_sum[48] ? '1 : acc_bytes_sum[47:0];
        drop_bytes_sat = drop_bytes_sum[48] ? '1 : drop_bytes_sum[47:0];
        acc_pkts_sat   = acc_pkts_sum[32] ? '1 : acc_pkts_sum[31:0];
        drop_pkts_sat  = drop_pkts_sum[32] ? '1 : drop_pkts_sum[31:0];
        elapsed        = ms_reg - mark_reg;
    end

    // One restoring step of each divider.
    always_comb
    begin
        acc_shift = {acc_rem_reg, acc_q_reg[48]};
        raw_shift = {raw_rem_reg, raw_q_reg[48]};
        acc_diff  = acc_shift - {1'b0, divisor_reg};
        raw_diff  = raw_shift - {1'b0, divisor_reg};
        acc_ge    = acc_shift >= {1'b0, divisor_reg};
        raw_ge    = raw_shift >= {1'b0, divisor_reg};
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        mac_next        = mac_reg;
        pos_next        = pos_reg;
        hl_next         = hl_reg;
        class_next      = class_reg;
        ms_next         = ms_reg;
        mark_next       = mark_reg;
        acc_bytes_next  = acc_bytes_reg;
        drop_bytes_next = drop_bytes_reg;
        acc_pkts_next   = acc_pkts_reg;
        drop_pkts_next  = drop_pkts_reg;
        out_valid_next  = out_valid_reg;
        out_beat_next   = out_beat_reg;
        meas_next       = meas_reg;
        acc_q_next      = acc_q_reg;
        raw_q_next      = raw_q_reg;
        acc_rem_next    = acc_rem_reg;
        raw_rem_next    = raw_rem_reg;
        divisor_next    = divisor_reg;

        if (mac_wr_en)
            mac_next = mac_wr_data;

        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (take && frame_beat.command == CMD_TICK)
                    ms_next = ms_reg + 32'd1;
                else if (take && frame_beat.command == CMD_BYTE)
                begin
                    pos_next   = pos_inc;
                    hl_next    = hl_byte;
                    class_next = cls_byte;
                    if (frame_beat.last_byte)
                    begin
                        pos_next   = '0;
                        hl_next    = HDR_LEN_RESET;
                        class_next = CLASS_MAGIC;
                        case (cls_final)
                            CLASS_UNKNOWN:
                            begin
                                drop_bytes_next           = drop_bytes_sat;
                                drop_pkts_next            = drop_pkts_sat;
                                out_valid_next            = 1'b1;
                                out_beat_next             = '0;
                                out_beat_next.frame_class = CLASS_UNKNOWN;
                            end
                            CLASS_FOR_US:
                            begin
                                acc_bytes_next            = acc_bytes_sat;
                                acc_pkts_next             = acc_pkts_sat;
                                out_valid_next            = 1'b1;
                                out_beat_next             = '0;
                                out_beat_next.frame_class = CLASS_FOR_US;
                            end
                            default:
                            begin
                                meas_next                  = '0;
                                meas_next.frame_class      = CLASS_MAGIC;
                                meas_next.interval_ms      = elapsed;
                                meas_next.accepted_bytes   = acc_bytes_sat;
                                meas_next.dropped_bytes    = drop_bytes_reg;
                                meas_next.accepted_packets = acc_pkts_sat;
                                meas_next.dropped_packets  = drop_pkts_reg;
                                acc_q_next      = {1'b0, acc_bytes_sat};
                                raw_q_next      = {1'b0, acc_bytes_sat} + {1'b0, drop_bytes_reg};
                                acc_rem_next    = '0;
                                raw_rem_next    = '0;
                                divisor_next    = elapsed;
                                cnt_next        = DIV_CNT_W'(DIV_STEPS);
                                acc_bytes_next  = '0;
                                drop_bytes_next = '0;
                                acc_pkts_next   = '0;
                                drop_pkts_next  = '0;
                                mark_next       = ms_reg;
                                state_next      = ST_DIV;
                            end
                        endcase
                    end
                end
            end
            ST_DIV:
            begin
                acc_q_next   = {acc_q_reg[47:0], acc_ge};
                raw_q_next   = {raw_q_reg[47:0], raw_ge};
                acc_rem_next = acc_ge ? acc_diff[31:0] : acc_shift[31:0];
                raw_rem_next = raw_ge ? raw_diff[31:0] : raw_shift[31:0];
                cnt_next     = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    out_beat_next = meas_reg;
                    if (meas_reg.interval_ms != '0)
                    begin
                        out_beat_next.accepted_kbits = {acc_q_reg[47:0], 3'b000};
                        out_beat_next.raw_kbits      = {raw_q_reg, 3'b000};
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            cnt_reg        <= '0;
            mac_reg        <= '0;
            pos_reg        <= '0;
            hl_reg         <= HDR_LEN_RESET;
            class_reg      <= CLASS_MAGIC;
            ms_reg         <= '0;
            mark_reg       <= '0;
            acc_bytes_reg  <= '0;
            drop_bytes_reg <= '0;
            acc_pkts_reg   <= '0;
            drop_pkts_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            mac_reg        <= mac_next;
            pos_reg        <= pos_next;
            hl_reg         <= hl_next;
            class_reg      <= class_next;
            ms_reg         <= ms_next;
            mark_reg       <= mark_next;
            acc_bytes_reg  <= acc_bytes_next;
            drop_bytes_reg <= drop_bytes_next;
            acc_pkts_reg   <= acc_pkts_next;
            drop_pkts_reg  <= drop_pkts_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
        meas_reg     <= meas_next;
        acc_q_reg    <= acc_q_next;
        raw_q_reg    <= raw_q_next;
        acc_rem_reg  <= acc_rem_next;
        raw_rem_reg  <= raw_rem_next;
        divisor_reg  <= divisor_next;
    end

endmodule

// ----- hdl/mutm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the throughput meter and its bind.
`include "magic_udp_frame_throughput_meter_defines.svh"

module mutm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_stall,
    input mutm_pkg::result_beat_t result_beat
);
    import mutm_pkg::*;

    `MUTM_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !result_valid)

    `MUTM_ASSERT(a_hold_stalled,
        result_valid && result_stall |=> result_valid && $stable(result_beat))

    `MUTM_ASSERT(a_plain_zero, result_valid && result_beat.frame_class != CLASS_MAGIC |->
        result_beat.interval_ms == '0 && result_beat.accepted_kbits == '0 &&
        result_beat.raw_kbits == '0 && result_beat.accepted_bytes == '0 &&
        result_beat.dropped_bytes == '0 && result_beat.accepted_packets == '0 &&
        result_beat.dropped_packets == '0)

    `MUTM_ASSERT(a_rate_shape, result_valid && result_beat.frame_class == CLASS_MAGIC |->
        result_beat.accepted_kbits[2:0] == 3'b000 && result_beat.raw_kbits[2:0] == 3'b000 &&
        52'(result_beat.accepted_kbits) <= result_beat.raw_kbits &&
        (result_beat.interval_ms != '0 || result_beat.raw_kbits == '0) &&
        result_beat.accepted_packets != '0)

endmodule

bind magic_udp_frame_throughput_meter mutm_checker u_mutm_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the UDP greeting-frame throughput meter, checked against an in-bench model.
module tb_top;
    import mutm_pkg::*;

    localparam int FRAME_LIMIT   = 2048;
    localparam int GREETING_LEN  = 32;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [7:0] GREETING [GREETING_LEN] = '{
        8'h48, 8'h65, 8'h6c, 8'h6c, 8'h6f, 8'h20, 8'h77, 8'h6f,
        8'h72, 8'h6c, 8'h64, 8'h21, 8'h20, 8'h47, 8'h65, 8'h6e,
        8'h6f, 8'h64, 8'h65, 8'h20, 8'h69, 8'h73, 8'h20, 8'h67,
        8'h72, 8'h65, 8'h65, 8'h74, 8'h69, 8'h6e, 8'h67, 8'h2e
    };

    typedef struct {
        int         len;
        int         ihl;
        bit         mac_ok;
        bit         udp_ok;
        bit         greet_ok;
        int         lead_ticks;
        bit         typed;
        logic [1:0] cls;
    } frame_row_t;

    logic         clk;
    logic         rst_n;
    logic         mac_wr_en;
    logic [47:0]  mac_wr_data;
    logic         frame_valid;
    logic         frame_stall;
    frame_beat_t  frame_beat;
    logic         result_valid;
    logic         result_stall;
    result_beat_t result_beat;

    logic [47:0]  own_mac;
    int unsigned  byte_index;
    logic [5:0]   ip_hdr_len;
    logic [1:0]   frame_verdict;
    logic [31:0]  now_ms;
    logic [31:0]  mark_ms;
    logic [47:0]  good_bytes;
    logic [47:0]  bad_bytes;
    logic [31:0]  good_frames;
    logic [31:0]  bad_frames;

    result_beat_t expected_reports [$];
    logic [7:0]   frame_buf [$];
    int           mismatch_count;
    int           beats_sent;
    int           frames_sent;
    bit           idle_on;
    bit           hold_trigger;

    frame_row_t directed_rows [13] = '{
        '{1,    5,  1, 1, 1, 2, 1, CLASS_UNKNOWN},
        '{23,   5,  1, 1, 1, 0, 1, CLASS_UNKNOWN},
        '{24,   5,  1, 1, 1, 1, 1, CLASS_FOR_US},
        '{74,   5,  1, 1, 1, 3, 0, CLASS_MAGIC},
        '{74,   5,  0, 1, 1, 1, 1, CLASS_UNKNOWN},
        '{74,   5,  1, 0, 1, 1, 1, CLASS_UNKNOWN},
        '{74,   5,  1, 1, 0, 1, 1, CLASS_FOR_US},
        '{73,   5,  1, 1, 1, 1, 1, CLASS_FOR_US},
        '{74,   5,  1, 1, 1, 0, 0, CLASS_MAGIC},
        '{114,  15, 1, 1, 1, 5, 0, CLASS_MAGIC},
        '{60,   0,  1, 1, 1, 2, 0, CLASS_MAGIC},
        '{60,   1,  1, 1, 1, 2, 0, CLASS_MAGIC},
        '{90,   6,  1, 1, 1, 7, 0, CLASS_MAGIC}
    };

    magic_udp_frame_throughput_meter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .mac_wr_en    (mac_wr_en),
        .mac_wr_data  (mac_wr_data),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_beat   (frame_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void reset_meter_state();
        own_mac       = '0;
        byte_index    = 0;
        ip_hdr_len    = HDR_LEN_RESET;
        frame_verdict = CLASS_MAGIC;
        now_ms        = '0;
        mark_ms       = '0;
        good_bytes    = '0;
        bad_bytes     = '0;
        good_frames   = '0;
        bad_frames    = '0;
    endfunction

    function automatic bit classify_beat(input frame_beat_t b, output result_beat_t r);
        int unsigned n;
        int unsigned start;
        logic [1:0]  cls;
        logic [31:0] elapsed;
        logic [48:0] byte_sum;
        logic [63:0] quot;
        r = '0;
        if (b.command == CMD_TICK)
        begin
            now_ms = now_ms + 32'd1;
            return 1'b0;
        end
        if (byte_index < FRAME_LIMIT)
        begin
            start = PAYLOAD_BASE + ip_hdr_len;
            if (byte_index < MAC_LEN && b.frame_byte != own_mac[8 * (5 - byte_index) +: 8])
                frame_verdict = CLASS_UNKNOWN;
            if (byte_index == IHL_POS)
                ip_hdr_len = {b.frame_byte[3:0], 2'b00};
            if (byte_index == PROTO_POS && b.frame_byte != PROTO_UDP)
                frame_verdict = CLASS_UNKNOWN;
            if (byte_index >= start && byte_index < start + GREETING_LEN &&
                b.frame_byte != GREETING[byte_index - start] && frame_verdict == CLASS_MAGIC)
                frame_verdict = CLASS_FOR_US;
            byte_index++;
        end
        if (!b.last_byte)
            return 1'b0;

        n   = byte_index;
        cls = frame_verdict;
        if (n < MIN_FRAME_LEN)
            cls = CLASS_UNKNOWN;
        else if (cls == CLASS_MAGIC && n < PAYLOAD_BASE + ip_hdr_len + GREETING_LEN)
            cls = CLASS_FOR_US;
        byte_index    = 0;
        ip_hdr_len    = HDR_LEN_RESET;
        frame_verdict = CLASS_MAGIC;
        r.frame_class = cls;

        if (cls == CLASS_UNKNOWN)
        begin
            if (bad_frames != '1)
                bad_frames = bad_frames + 32'd1;
            byte_sum  = {1'b0, bad_bytes} + 49'(n);
            bad_bytes = byte_sum[48] ? '1 : byte_sum[47:0];
            return 1'b1;
        end
        if (good_frames != '1)
            good_frames = good_frames + 32'd1;
        byte_sum   = {1'b0, good_bytes} + 49'(n);
        good_bytes = byte_sum[48] ? '1 : byte_sum[47:0];
        if (cls != CLASS_MAGIC)
            return 1'b1;

        elapsed       = now_ms - mark_ms;
        r.interval_ms = elapsed;
        if (elapsed != 0)
        begin
            quot             = {16'b0, good_bytes} / {32'b0, elapsed};
            quot             = quot << 3;
            r.accepted_kbits = quot[50:0];
            quot             = ({16'b0, good_bytes} + {16'b0, bad_bytes}) / {32'b0, elapsed};
            quot             = quot << 3;
            r.raw_kbits      = quot[51:0];
        end
        r.accepted_bytes   = good_bytes;
        r.dropped_bytes    = bad_bytes;
        r.accepted_packets = good_frames;
        r.dropped_packets  = bad_frames;
        good_bytes  = '0;
        bad_bytes   = '0;
        good_frames = '0;
        bad_frames  = '0;
        mark_ms     = now_ms;
        return 1'b1;
    endfunction

    task automatic push_beat(input frame_beat_t b, input bit typed, input logic [1:0] cls);
        result_beat_t r;
        while (idle_on && $urandom_range(99) < 8)
        begin
            frame_valid <= 1'b0;
            @(negedge clk);
        end
        frame_valid <= 1'b1;
        frame_beat  <= b;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        beats_sent++;
        if (classify_beat(b, r))
        begin
            if (typed)
            begin
                r = '0;
                r.frame_class = cls;
            end
            expected_reports.push_back(r);
            frames_sent++;
        end
        @(negedge clk);
    endtask

    task automatic push_tick();
        frame_beat_t b;
        b.command    = CMD_TICK;
        b.frame_byte = 8'($urandom);
        b.last_byte  = 1'($urandom);
        push_beat(b, 1'b0, CLASS_UNKNOWN);
    endtask

    task automatic build_frame(input int len, input int ihl, input bit mac_ok,
                               input bit udp_ok, input bit greet_ok);
        int total;
        int start;
        int k;
        start = PAYLOAD_BASE + 4 * ihl;
        total = (len > start + GREETING_LEN) ? len : start + GREETING_LEN;
        frame_buf.delete();
        repeat (total)
            frame_buf.push_back(8'($urandom));
        for (k = 0; k < MAC_LEN; k++)
            frame_buf[k] = own_mac[8 * (5 - k) +: 8];
        if (!mac_ok)
        begin
            k = $urandom_range(MAC_LEN - 1);
            frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
        end
        frame_buf[IHL_POS] = {4'($urandom), 4'(ihl)};
        frame_buf[PROTO_POS] = udp_ok ? PROTO_UDP : PROTO_UDP ^ 8'($urandom_range(1, 255));
        for (k = 0; k < GREETING_LEN; k++)
            frame_buf[start + k] = GREETING[k];
        if (!greet_ok)
        begin
            k = start + $urandom_range(GREETING_LEN - 1);
            frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
        end
        while (frame_buf.size() > len)
            void'(frame_buf.pop_back());
    endtask

    task automatic send_frame(input int lead_ticks, input int tick_pct, input bit typed,
                              input logic [1:0] cls);
        frame_beat_t b;
        int i;
        repeat (lead_ticks)
            push_tick();
        for (i = 0; i < frame_buf.size(); i++)
        begin
            while ($urandom_range(99) < tick_pct)
                push_tick();
            b.command    = CMD_BYTE;
            b.frame_byte = frame_buf[i];
            b.last_byte  = (i == frame_buf.size() - 1);
            push_beat(b, typed, cls);
        end
    endtask

    task automatic drain_results();
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_mac(input logic [47:0] value);
        mac_wr_en   <= 1'b1;
        mac_wr_data <= value;
        @(negedge clk);
        mac_wr_en <= 1'b0;
        own_mac = value;
        @(negedge clk);
    endtask

    task automatic run_random_frames(input int beat_goal, input int frame_goal);
        int first_beat;
        int first_frame;
        int pick;
        int ihl;
        int natural;
        first_beat  = beats_sent;
        first_frame = frames_sent;
        while (beats_sent - first_beat < beat_goal || frames_sent - first_frame < frame_goal)
        begin
            pick    = $urandom_range(99);
            ihl     = $urandom_range(5, 15);
            natural = PAYLOAD_BASE + 4 * ihl + GREETING_LEN;
            if (pick < 55)
                build_frame(natural + $urandom_range(16), ihl, 1, 1, 1);
            else if (pick < 65)
                build_frame(natural + $urandom_range(8), ihl, 1, 1, 0);
            else if (pick < 72)
                build_frame(natural + $urandom_range(8), ihl, 0, 1, 1);
            else if (pick < 79)
                build_frame(natural + $urandom_range(8), ihl, 1, 0, 1);
            else if (pick < 89)
                build_frame($urandom_range(1, 80), $urandom_range(15), 1, 1, 1);
            else if (pick < 93)
            begin
                ihl = $urandom_range(4);
                build_frame(PAYLOAD_BASE + 4 * ihl + GREETING_LEN + $urandom_range(8),
                            ihl, 1, 1, 1);
            end
            else
            begin
                frame_buf.delete();
                repeat ($urandom_range(1, 100))
                    frame_buf.push_back(8'($urandom));
            end
            send_frame($urandom_range(4), 3, 1'b0, CLASS_UNKNOWN);
        end
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    endtask

    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_reports.size() == 0)
                report_field("unexpected result, frame_class", 64'hx, result_beat.frame_class);
            else
            begin
                want = expected_reports.pop_front();
                if (want.frame_class !== result_beat.frame_class)
                    report_field("frame_class", want.frame_class, result_beat.frame_class);
                if (want.interval_ms !== result_beat.interval_ms)
                    report_field("interval_ms", want.interval_ms, result_beat.interval_ms);
                if (want.accepted_kbits !== result_beat.accepted_kbits)
                    report_field("accepted_kbits", want.accepted_kbits,
                                 result_beat.accepted_kbits);
                if (want.raw_kbits !== result_beat.raw_kbits)
                    report_field("raw_kbits", want.raw_kbits, result_beat.raw_kbits);
                if (want.accepted_bytes !== result_beat.accepted_bytes)
                    report_field("accepted_bytes", want.accepted_bytes,
                                 result_beat.accepted_bytes);
                if (want.dropped_bytes !== result_beat.dropped_bytes)
                    report_field("dropped_bytes", want.dropped_bytes,
                                 result_beat.dropped_bytes);
                if (want.accepted_packets !== result_beat.accepted_packets)
                    report_field("accepted_packets", want.accepted_packets,
                                 result_beat.accepted_packets);
                if (want.dropped_packets !== result_beat.dropped_packets)
                    report_field("dropped_packets", want.dropped_packets,
                                 result_beat.dropped_packets);
            end
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_trigger)
            begin
                hold_trigger = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            result_stall <= idle_on && ($urandom_range(99) < 8);
        end
    end

    initial
    begin
        logic [63:0] rand_mac;
        int          r;
        int          phase;
        rst_n          = 1'b0;
        mac_wr_en      = 1'b0;
        mac_wr_data    = '0;
        frame_valid    = 1'b0;
        frame_beat     = '0;
        idle_on        = 1'b1;
        hold_trigger   = 1'b0;
        mismatch_count = 0;
        beats_sent     = 0;
        frames_sent    = 0;
        reset_meter_state();
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_mac(48'hFFFF_FFFF_FFFF);
        for (r = 0; r < $size(directed_rows); r++)
        begin
            build_frame(directed_rows[r].len, directed_rows[r].ihl, directed_rows[r].mac_ok,
                        directed_rows[r].udp_ok, directed_rows[r].greet_ok);
            send_frame(directed_rows[r].lead_ticks, 2, directed_rows[r].typed,
                       directed_rows[r].cls);
        end
        frame_valid <= 1'b0;
        drain_results();

        for (phase = 0; phase < 4; phase++)
        begin
            rand_mac = {$urandom, $urandom};
            case (phase)
                0:       write_mac(48'h0);
                2:       write_mac(48'hFFFF_FFFF_FFFF);
                default: write_mac(rand_mac[47:0]);
            endcase
            idle_on = (phase != 2);
            if (phase == 1)
                hold_trigger = 1'b1;
            run_random_frames(250, 3);
            frame_valid <= 1'b0;
            drain_results();
        end

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mutm_pkg.sv
hdl/magic_udp_frame_throughput_meter.sv
hdl/mutm_checker.sv
test/tb_top.sv
